// File: hdl/fpu_pkg.sv
// Package for the truncating single-precision add/multiply/divide unit.
// Opcodes, field widths and special-value constants. No dependencies.
`default_nettype none
package fpu_pkg;
   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_MUL = 2'd1,
      FUNC_DIV = 2'd2,
      FUNC_RSV = 2'd3
   } func_type;

   localparam logic [31:0] NAN_PATTERN = 32'h7F80_0001;
   localparam logic [7:0]  EXP_TOP     = 8'd255;
   localparam int          EXP_BIAS    = 127;
   localparam int          SIG_W       = 24;
   localparam int          ACC_W       = 50;
   localparam int          EXP_W       = 11;

   typedef logic signed [EXP_W-1:0] exp_type;
endpackage
`default_nettype wire

// File: hdl/fpu_stream_if.sv
// Valid/ready channel interface for the unit's request and response beats.
// Depends on nothing; payload width is a parameter.
`default_nettype none
interface fpu_stream_if #(
   parameter int W = 66
) (
   input wire logic clock
);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/fp32_add_mul_div_truncating_unit.sv
// Truncating IEEE 754 single-precision add, multiply and divide.
// Special operands are resolved straight from the request; other adds take one-bit-per-cycle
// align and normalize shifts, and multiply/divide run a bit-serial loop (one bit per
// cycle over the 24-bit significand) followed by one-bit-per-cycle normalize shifts.
// Throughput: one item at a time; a new request is taken once the response
// register is free. Synchronous active-high reset clears control state only.
`default_nettype none
module fp32_add_mul_div_truncating_unit
   import fpu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   fpu_stream_if.sink   req,
   fpu_stream_if.source rsp
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRENORM,
      ST_ALIGN,
      ST_ITER,
      ST_NORM,
      ST_DENORM,
      ST_DONE
   } state_type;

   state_type         state_ff;
   func_type          func_ff;
   logic              sign_ff;
   exp_type           exp_ff;
   logic [ACC_W-1:0]  acc_ff;    // add: larger-exponent sig; mul: product; div: remainder
   logic [ACC_W-1:0]  opb_ff;    // add: smaller-exponent sig; mul: multiplicand; div: divisor
   logic [SIG_W-1:0]  quo_ff;    // div quotient / mul multiplier
   logic [5:0]        cnt_ff;
   logic              sb_ff;
   logic              pa_ff;     // prenorm done on a
   logic [31:0]       res_ff;
   logic              rsp_valid_ff;

   logic [1:0]  f_in;
   logic [31:0] a_in, b_in;
   assign f_in = req.data[65:64];
   assign a_in = req.data[63:32];
   assign b_in = req.data[31:0];

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = res_ff;

   logic        sa, sbb, s_x;
   logic [7:0]  ea, eb;
   logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
   logic [SIG_W-1:0] ma, mb;
   assign sa    = a_in[31];
   assign sbb   = b_in[31];
   assign s_x   = sa ^ sbb;
   assign ea    = a_in[30:23];
   assign eb    = b_in[30:23];
   assign nan_a = (ea == EXP_TOP) && (a_in[22:0] != 23'd0);
   assign nan_b = (eb == EXP_TOP) && (b_in[22:0] != 23'd0);
   assign inf_a = (ea == EXP_TOP) && (a_in[22:0] == 23'd0);
   assign inf_b = (eb == EXP_TOP) && (b_in[22:0] == 23'd0);
   assign zer_a = a_in[30:0] == 31'd0;
   assign zer_b = b_in[30:0] == 31'd0;
   assign ma    = {ea != 8'd0, a_in[22:0]};
   assign mb    = {eb != 8'd0, b_in[22:0]};

   exp_type eea, eeb;
   assign eea = (ea == 8'd0) ? exp_type'(1) : exp_type'({3'd0, ea});
   assign eeb = (eb == 8'd0) ? exp_type'(1) : exp_type'({3'd0, eb});

   // Special operands resolved combinationally from the request beat.
   logic        spec_hit;
   logic [31:0] spec_res;
   always_comb begin
      spec_hit = 1'b1;
      spec_res = NAN_PATTERN;
      case (func_type'(f_in))
         FUNC_ADD: begin
            if (nan_a || nan_b) spec_res = NAN_PATTERN;
            else if (inf_a) spec_res = (inf_b && sa != sbb) ? NAN_PATTERN : a_in;
            else if (inf_b) spec_res = b_in;
            else if (zer_a) spec_res = zer_b ? {sa & sbb, 31'd0} : b_in;
            else if (zer_b) spec_res = a_in;
            else if (eea - eeb > exp_type'(31)) spec_res = a_in;
            else if (eeb - eea > exp_type'(31)) spec_res = b_in;
            else spec_hit = 1'b0;
         end
         FUNC_MUL: begin
            if (nan_a || nan_b) spec_res = NAN_PATTERN;
            else if (zer_a || zer_b)
               spec_res = (inf_a || inf_b) ? NAN_PATTERN : {s_x, 31'd0};
            else if (inf_a || inf_b) spec_res = {s_x, 8'hFF, 23'd0};
            else spec_hit = 1'b0;
         end
         FUNC_DIV: begin
            if (nan_a || nan_b) spec_res = NAN_PATTERN;
            else if (zer_b) spec_res = zer_a ? NAN_PATTERN : {s_x, 8'hFF, 23'd0};
            else if (zer_a) spec_res = {s_x, 31'd0};
            else if (inf_a) spec_res = inf_b ? NAN_PATTERN : {s_x, 8'hFF, 23'd0};
            else if (inf_b) spec_res = {s_x, 31'd0};
            else spec_hit = 1'b0;
         end
         default: spec_res = NAN_PATTERN;
      endcase
   end

   // Add path: exponent difference and combine, staged in ALIGN.
   exp_type ediff;
   assign ediff = exp_ff;  // during ALIGN exp_ff holds remaining shift

   logic [ACC_W-1:0] add_sum;
   logic             add_sgn;
   always_comb begin
      if (sign_ff == sb_ff) begin
         add_sum = acc_ff + opb_ff;
         add_sgn = sign_ff;
      end else if (acc_ff >= opb_ff) begin
         add_sum = acc_ff - opb_ff;
         add_sgn = sign_ff;
      end else begin
         add_sum = opb_ff - acc_ff;
         add_sgn = sb_ff;
      end
   end

   logic [ACC_W-1:0] rem_sh, rem_sub;
   assign rem_sh  = {acc_ff[ACC_W-2:0], 1'b0};
   assign rem_sub = rem_sh - opb_ff;

   // Normalize target: leading one at bit 23 of acc_ff.
   logic hi_any;
   assign hi_any = acc_ff[ACC_W-1:SIG_W] != '0;

   logic [31:0] packed_v;
   assign packed_v = {sign_ff, exp_ff[7:0], acc_ff[22:0]};

   exp_type er_ff;   // add result exponent held across ALIGN

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  func_ff <= func_type'(f_in);
                  pa_ff   <= 1'b0;
                  cnt_ff  <= '0;
                  if (spec_hit) begin
                     res_ff   <= spec_res;
                     state_ff <= ST_DONE;
                  end else begin
                     case (func_type'(f_in))
                        FUNC_ADD: begin
                           if (eea >= eeb) begin
                              sign_ff <= sa;
                              sb_ff   <= sbb;
                              acc_ff <= ACC_W'(ma);
                              opb_ff <= ACC_W'(mb);
                              er_ff  <= eea;
                              exp_ff <= eea - eeb;
                           end else begin
                              acc_ff <= ACC_W'(mb);
                              opb_ff <= ACC_W'(ma);
                              sign_ff <= sbb;
                              sb_ff   <= sa;
                              er_ff  <= eeb;
                              exp_ff <= eeb - eea;
                           end
                           state_ff <= ST_ALIGN;
                        end
                        FUNC_MUL: begin
                           sign_ff <= s_x;
                           acc_ff  <= '0;
                           opb_ff  <= ACC_W'(ma);
                           quo_ff  <= mb;
                           exp_ff  <= eea + eeb - exp_type'(EXP_BIAS) - exp_type'(23);
                           state_ff <= ST_ITER;
                        end
                        FUNC_DIV: begin
                           sign_ff <= s_x;
                           acc_ff  <= ACC_W'(ma);
                           opb_ff  <= ACC_W'(mb);
                           exp_ff  <= eea - eeb + exp_type'(EXP_BIAS);
                           state_ff <= ST_PRENORM;
                        end
                        default: state_ff <= ST_DONE;
                     endcase
                  end
               end
            end
            ST_PRENORM: begin
               // exponent adjust: a shift lowers, b shift raises
               if (!pa_ff) begin
                  if (!acc_ff[SIG_W-1]) begin
                     acc_ff <= {acc_ff[ACC_W-2:0], 1'b0};
                     exp_ff <= exp_ff - exp_type'(1);
                  end else pa_ff <= 1'b1;
               end else if (!opb_ff[SIG_W-1]) begin
                  opb_ff <= {opb_ff[ACC_W-2:0], 1'b0};
                  exp_ff <= exp_ff + exp_type'(1);
               end else begin
                  exp_ff   <= exp_ff - exp_type'(1);  // quotient has 25 bits, frac 24
                  acc_ff   <= acc_ff;
                  state_ff <= ST_ITER;
               end
            end
            ST_ALIGN: begin
               if (ediff != exp_type'(0)) begin
                  opb_ff <= opb_ff >> 1;
                  exp_ff <= exp_ff - exp_type'(1);
               end else begin
                  if (add_sum == '0) begin
                     res_ff   <= 32'd0;
                     state_ff <= ST_DONE;
                  end else begin
                     acc_ff   <= add_sum;
                     sign_ff  <= add_sgn;
                     exp_ff   <= er_ff;
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_ITER: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (func_ff == FUNC_MUL) begin
                  // shift-add, multiplier LSB first
                  if (quo_ff[0]) acc_ff <= acc_ff + opb_ff;
                  opb_ff <= {opb_ff[ACC_W-2:0], 1'b0};
                  quo_ff <= quo_ff >> 1;
                  if (cnt_ff == 6'd23) state_ff <= ST_NORM;
               end else begin
                  // restoring division, 25 quotient bits
                  if (cnt_ff == 6'd0) begin
                     if (acc_ff >= opb_ff) begin
                        acc_ff <= acc_ff - opb_ff;
                        quo_ff <= SIG_W'(1);
                     end else quo_ff <= '0;
                  end else if (cnt_ff == 6'd24) begin
                     acc_ff   <= ACC_W'({quo_ff, rem_sh >= opb_ff});
                     state_ff <= ST_NORM;
                  end else begin
                     if (rem_sh >= opb_ff) begin
                        acc_ff <= rem_sub;
                        quo_ff <= {quo_ff[SIG_W-2:0], 1'b1};
                     end else begin
                        acc_ff <= rem_sh;
                        quo_ff <= {quo_ff[SIG_W-2:0], 1'b0};
                     end
                  end
               end
            end
            ST_NORM: begin
               if (hi_any) begin
                  acc_ff <= acc_ff >> 1;
                  exp_ff <= exp_ff + exp_type'(1);
               end else if (!acc_ff[SIG_W-1] && exp_ff > exp_type'(-40)) begin
                  acc_ff <= {acc_ff[ACC_W-2:0], 1'b0};
                  exp_ff <= exp_ff - exp_type'(1);
               end else if (exp_ff >= exp_type'(EXP_TOP)) begin
                  res_ff   <= {sign_ff, 8'hFF, 23'd0};
                  state_ff <= ST_DONE;
               end else if (exp_ff < exp_type'(-23)) begin
                  res_ff   <= {sign_ff, 31'd0};
                  state_ff <= ST_DONE;
               end else if (exp_ff <= exp_type'(0)) begin
                  acc_ff   <= acc_ff >> 1;
                  state_ff <= ST_DENORM;
               end else begin
                  res_ff   <= packed_v;
                  state_ff <= ST_DONE;
               end
            end
            ST_DENORM: begin
               if (exp_ff != exp_type'(0)) begin
                  acc_ff <= acc_ff >> 1;
                  exp_ff <= exp_ff + exp_type'(1);
               end else begin
                  res_ff   <= {sign_ff, 8'd0, acc_ff[22:0]};
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: test/fp32_add_mul_div_truncating_checker.sv
// Checker for the truncating fp32 add/multiply/divide unit: watches both channels,
// predicts each result from the request beat and compares in order.
// Depends on fpu_pkg.
module fp32_add_mul_div_truncating_checker
   import fpu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic [65:0] req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic [31:0] rsp_data,
   output int fail_count,
   output int pending_count
);
   logic [31:0] expected_results[$];

   function automatic logic is_nan_bits(logic [31:0] x);
      return x[30:23] == EXP_TOP && x[22:0] != 0;
   endfunction

   function automatic logic is_inf_bits(logic [31:0] x);
      return x[30:23] == EXP_TOP && x[22:0] == 0;
   endfunction

   function automatic logic is_zero_bits(logic [31:0] x);
      return x[30:0] == 0;
   endfunction

   function automatic logic [31:0] inf_bits(logic s);
      return {s, 8'hFF, 23'd0};
   endfunction

   function automatic longint unsigned significand(logic [31:0] x, output int e);
      if (x[30:23] == 0) begin
         e = 1;
         return x[22:0];
      end
      e = x[30:23];
      return {1'b1, x[22:0]};
   endfunction

   function automatic logic [31:0] truncate_pack(logic s, int e, longint unsigned m,
                                                 int frac);
      int p;
      p = 63;
      while (p > 0 && m[p] == 1'b0) p--;
      e += p - frac;
      if (p > 23) m = m >> (p - 23);
      else m = m << (23 - p);
      if (e >= 255) return inf_bits(s);
      if (e <= 0) begin
         if (e < -23) return {s, 31'd0};
         m = m >> (1 - e);
         return {s, 8'd0, m[22:0]};
      end
      return {s, e[7:0], m[22:0]};
   endfunction

   function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
      int ea, eb, er, d;
      longint unsigned ma, mb, mr;
      logic sr;
      if (is_nan_bits(a) || is_nan_bits(b)) return NAN_PATTERN;
      if (is_inf_bits(a)) begin
         if (is_inf_bits(b) && a[31] != b[31]) return NAN_PATTERN;
         return a;
      end
      if (is_inf_bits(b)) return b;
      if (is_zero_bits(a)) return is_zero_bits(b) ? {a[31] & b[31], 31'd0} : b;
      if (is_zero_bits(b)) return a;
      ma = significand(a, ea);
      mb = significand(b, eb);
      d = ea - eb;
      er = ea;
      if (d > 0) begin
         if (d > 31) return a;
         mb = mb >> d;
      end else if (d < 0) begin
         if (d < -31) return b;
         ma = ma >> -d;
         er = eb;
      end
      if (a[31] == b[31]) begin
         mr = ma + mb;
         sr = a[31];
      end else if (ma >= mb) begin
         mr = ma - mb;
         sr = a[31];
      end else begin
         mr = mb - ma;
         sr = b[31];
      end
      if (mr == 0) return 32'd0;
      return truncate_pack(sr, er, mr, 23);
   endfunction

   function automatic logic [31:0] fp_product(logic [31:0] a, logic [31:0] b);
      int ea, eb;
      longint unsigned ma, mb;
      logic s;
      s = a[31] ^ b[31];
      if (is_nan_bits(a) || is_nan_bits(b)) return NAN_PATTERN;
      if (is_zero_bits(a) || is_zero_bits(b)) begin
         if (is_inf_bits(a) || is_inf_bits(b)) return NAN_PATTERN;
         return {s, 31'd0};
      end
      if (is_inf_bits(a) || is_inf_bits(b)) return inf_bits(s);
      ma = significand(a, ea);
      mb = significand(b, eb);
      return truncate_pack(s, ea + eb - EXP_BIAS, ma * mb, 46);
   endfunction

   function automatic logic [31:0] fp_quotient(logic [31:0] a, logic [31:0] b);
      int ea, eb;
      longint unsigned ma, mb;
      logic s;
      s = a[31] ^ b[31];
      if (is_nan_bits(a) || is_nan_bits(b)) return NAN_PATTERN;
      if (is_zero_bits(b)) return is_zero_bits(a) ? NAN_PATTERN : inf_bits(s);
      if (is_zero_bits(a)) return {s, 31'd0};
      if (is_inf_bits(a)) return is_inf_bits(b) ? NAN_PATTERN : inf_bits(s);
      if (is_inf_bits(b)) return {s, 31'd0};
      ma = significand(a, ea);
      mb = significand(b, eb);
      while (ma[23] == 1'b0) begin
         ma = ma << 1;
         ea--;
      end
      while (mb[23] == 1'b0) begin
         mb = mb << 1;
         eb--;
      end
      return truncate_pack(s, ea - eb + EXP_BIAS, (ma << 24) / mb, 24);
   endfunction

   function automatic logic [31:0] fp_result(func_type f, logic [31:0] a, logic [31:0] b);
      case (f)
         FUNC_ADD: return fp_sum(a, b);
         FUNC_MUL: return fp_product(a, b);
         FUNC_DIV: return fp_quotient(a, b);
         default: return NAN_PATTERN;
      endcase
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(fp_result(func_type'(req_data[65:64]),
                                                 req_data[63:32], req_data[31:0]));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_data !== expected_results[0]) begin
                  $display("%0t: result_bits mismatch, expected %h, actual %h",
                           $time, expected_results[0], rsp_data);
                  fail_count <= fail_count + 1;
               end
               void'(expected_results.pop_front());
            end
         end
      end
   end
endmodule

// File: test/fp32_add_mul_div_truncating_unit_tb.sv
// Testbench top for the truncating fp32 add/multiply/divide unit: clock, reset,
// request stimulus with random gaps and response stalls, and the verdict.
// Depends on fpu_pkg, fpu_stream_if, the unit and its checker.
module fp32_add_mul_div_truncating_unit_tb;
   import fpu_pkg::*;

   logic clock;
   logic reset;
   logic quiet;
   int fail_count;
   int pending_count;

   fpu_stream_if #(.W(66)) req_if (.clock(clock));
   fpu_stream_if #(.W(32)) rsp_if (.clock(clock));

   fp32_add_mul_div_truncating_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   fp32_add_mul_div_truncating_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req_data(req_if.data),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_data(rsp_if.data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

   task automatic send_beat(func_type f, logic [31:0] a, logic [31:0] b);
      while (!quiet && $urandom_range(99) < 19) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {f, a, b};
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(9))
         0: x[30:23] = 8'd0;
         1: x[30:23] = 8'hFF;
         2: x[30:0] = 31'd0;
         3: x[30:23] = 8'($urandom_range(1, 24));
         4: x[30:23] = 8'($urandom_range(230, 254));
         5: x[30:23] = 8'($urandom_range(100, 154));
         default: ;
      endcase
      return x;
   endfunction

   initial begin
      logic [31:0] a;
      logic [31:0] b;
      int unsigned k;
      reset = 1'b1;
      quiet = 1'b0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // add/mul/div specials: nan, inf, signed zeros, cancellation, big exponent gap, subnormals, overflow
      send_beat(FUNC_ADD, 32'h7FC0_0000, 32'h3F80_0000);
      send_beat(FUNC_ADD, 32'h7F80_0000, 32'hFF80_0000);
      send_beat(FUNC_ADD, 32'hFF80_0000, 32'h3F80_0000);
      send_beat(FUNC_ADD, 32'h8000_0000, 32'h8000_0000);
      send_beat(FUNC_ADD, 32'h8000_0000, 32'h0000_0000);
      send_beat(FUNC_ADD, 32'h0000_0000, 32'hC040_0000);
      send_beat(FUNC_ADD, 32'h3FC0_0000, 32'hBFC0_0000);
      send_beat(FUNC_ADD, 32'h7F00_0000, 32'h3F80_0000);
      send_beat(FUNC_ADD, 32'h007F_FFFF, 32'h0000_0001);
      send_beat(FUNC_ADD, 32'h0040_0000, 32'h0000_0001);
      send_beat(FUNC_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
      send_beat(FUNC_MUL, 32'h0000_0000, 32'hFF80_0000);
      send_beat(FUNC_MUL, 32'h8000_0000, 32'h4000_0000);
      send_beat(FUNC_MUL, 32'hFF80_0000, 32'h4000_0000);
      send_beat(FUNC_MUL, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
      send_beat(FUNC_MUL, 32'h0080_0000, 32'h3400_0000);
      send_beat(FUNC_MUL, 32'h0000_0001, 32'h0000_0001);
      send_beat(FUNC_MUL, 32'h0000_0003, 32'h4B00_0000);
      send_beat(FUNC_DIV, 32'h0000_0000, 32'h8000_0000);
      send_beat(FUNC_DIV, 32'h7F80_0000, 32'hFF80_0000);
      send_beat(FUNC_DIV, 32'hBF80_0000, 32'h0000_0000);
      send_beat(FUNC_DIV, 32'h3F80_0000, 32'h7F80_0000);
      send_beat(FUNC_DIV, 32'h3F80_0000, 32'h4040_0000);
      send_beat(FUNC_DIV, 32'h0000_0001, 32'h7F7F_FFFF);
      send_beat(FUNC_RSV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (k = 0; k < 800; k++) begin
         quiet = (k >= 300 && k < 450);
         a = pick_operand();
         b = pick_operand();
         if ($urandom_range(3) == 0) b = {1'($urandom_range(1)), a[30:23], 23'($urandom)};
         send_beat(func_type'($urandom_range(19) == 0 ? 3 : $urandom_range(2)), a, b);
      end
      req_if.valid <= 1'b0;
      quiet = 1'b0;
      k = 0;
      while (pending_count != 0 && k < 20000) begin
         @(posedge clock);
         k++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
